FILE: design/sdz_pkg.sv
// Shared types, constants and the per-bit search step for the stick direction block.
`default_nettype none
package sdz_pkg;

   localparam int QuotWidth = 15;
   localparam logic [14:0] FULL_SCALE = 15'd32767;
   localparam logic [14:0] DEAD_ZONE_RESET = 15'd7849;

   // One component's search state: target, running k^2*s, running k*s, result bits so far.
   typedef struct packed {
      logic [61:0]        rhs;
      logic [61:0]        p;
      logic signed [48:0] ks;
      logic [14:0]        q;
   } lane_type;

   typedef struct packed {
      lane_type    lx;
      lane_type    ly;
      logic [31:0] s;
      logic        negx;
      logic        negy;
      logic        zero;
      logic        killx;
      logic        killy;
   } item_type;

   // Try setting bit j of q: k grows by 2^(j+1), so k^2*s grows by
   // 2^(j+2)*k*s + 2^(2j+2)*s. Keep the bit if the square stays within rhs.
   function automatic lane_type lane_step(lane_type l, logic [31:0] s, int j);
      logic signed [66:0] pt;
      lane_type           r;
      pt = $signed({5'b0, l.p})
         + ($signed({{18{l.ks[48]}}, l.ks}) <<< (j + 2))
         + $signed({35'b0, s} << (2 * j + 2));
      r = l;
      if (!pt[66] && (pt[65:0] <= {4'b0, l.rhs})) begin
         r.p  = pt[61:0];
         r.ks = l.ks + $signed({17'b0, s} << (j + 1));
         r.q  = l.q | (15'd1 << j);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: design/sdz_if.sv
// Channel interfaces for stick samples, direction results and the dead-zone register.
`default_nettype none
interface sdz_req_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] stick_x;
   logic signed [15:0] stick_y;
   modport source (output valid, output stick_x, output stick_y, input ready);
   modport sink (input valid, input stick_x, input stick_y, output ready);
endinterface

interface sdz_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   modport source (output valid, output dir_x, output dir_y, input ready);
   modport sink (input valid, input dir_x, input dir_y, output ready);
endinterface

interface sdz_csr_if;
   logic        valid;
   logic        ready;
   logic [14:0] dead_zone;
   modport source (output valid, output dead_zone, input ready);
   modport sink (input valid, input dead_zone, output ready);
endinterface
`default_nettype wire

FILE: design/sdz_front.sv
// Front end: magnitudes, squared radius, scaled targets and dead-zone flags.
`default_nettype none
module sdz_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [15:0]      stick_x,
   input  wire logic [15:0]      stick_y,
   input  wire logic [14:0]      dead_zone,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output sdz_pkg::item_type     out_item
);
   import sdz_pkg::*;

   logic [15:0] ax, ay;
   logic        a_vld_ff, b_vld_ff, a_ready;
   logic [31:0] s_ff;
   logic [29:0] kax_ff, kay_ff;
   logic [29:0] dz2_ff;
   logic        negx_ff, negy_ff, ltx_ff, lty_ff;
   item_type    item_in, item_ff;

   assign ax = stick_x[15] ? 16'(-stick_x) : stick_x;
   assign ay = stick_y[15] ? 16'(-stick_y) : stick_y;

   assign a_ready  = !b_vld_ff || out_ready;
   assign in_ready = !a_vld_ff || a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (in_ready) a_vld_ff <= in_valid;
         if (a_ready) b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s_ff    <= 32'(ax) * 32'(ax) + 32'(ay) * 32'(ay);
         kax_ff  <= 30'(ax) * 30'(FULL_SCALE);
         kay_ff  <= 30'(ay) * 30'(FULL_SCALE);
         dz2_ff  <= 30'(dead_zone) * 30'(dead_zone);
         negx_ff <= stick_x[15];
         negy_ff <= stick_y[15];
         ltx_ff  <= ax < {1'b0, dead_zone};
         lty_ff  <= ay < {1'b0, dead_zone};
      end
   end

   always_comb begin
      item_in.lx.rhs = {60'(kax_ff) * 60'(kax_ff), 2'b00};
      item_in.lx.p   = {30'b0, s_ff};
      item_in.lx.ks  = -$signed({17'b0, s_ff});
      item_in.lx.q   = '0;
      item_in.ly.rhs = {60'(kay_ff) * 60'(kay_ff), 2'b00};
      item_in.ly.p   = {30'b0, s_ff};
      item_in.ly.ks  = -$signed({17'b0, s_ff});
      item_in.ly.q   = '0;
      item_in.s      = s_ff;
      item_in.negx   = negx_ff;
      item_in.negy   = negy_ff;
      item_in.zero   = s_ff == 32'd0;
      item_in.killx  = (s_ff <= {2'b0, dz2_ff}) && ltx_ff;
      item_in.killy  = (s_ff <= {2'b0, dz2_ff}) && lty_ff;
   end

   always_ff @(posedge clock) begin
      if (a_vld_ff && a_ready) item_ff <= item_in;
   end

   assign out_valid = b_vld_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

FILE: design/sdz_cell.sv
// One search cell: decides one bit of both scaled direction components.
`default_nettype none
module sdz_cell #(
   parameter int BIT_POS = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  sdz_pkg::item_type     in_item,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output sdz_pkg::item_type     out_item
);
   import sdz_pkg::*;

   logic     vld_ff;
   item_type item_in, item_ff;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      item_in    = in_item;
      item_in.lx = lane_step(in_item.lx, in_item.s, BIT_POS);
      item_in.ly = lane_step(in_item.ly, in_item.s, BIT_POS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) item_ff <= item_in;
   end

   assign out_valid = vld_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

FILE: design/sdz_back.sv
// Output stage: apply sign, zero-magnitude and dead-zone rules, hold the result.
`default_nettype none
module sdz_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  sdz_pkg::item_type     in_item,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [15:0]           dir_x,
   output logic [15:0]           dir_y
);
   import sdz_pkg::*;

   logic        vld_ff;
   logic [15:0] dx_in, dy_in, dx_ff, dy_ff;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      if (in_item.zero || in_item.killx) dx_in = '0;
      else if (in_item.negx) dx_in = 16'd0 - {1'b0, in_item.lx.q};
      else dx_in = {1'b0, in_item.lx.q};
      if (in_item.zero || in_item.killy) dy_in = '0;
      else if (in_item.negy) dy_in = 16'd0 - {1'b0, in_item.ly.q};
      else dy_in = {1'b0, in_item.ly.q};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   assign out_valid = vld_ff;
   assign dir_x     = dx_ff;
   assign dir_y     = dy_ff;
endmodule
`default_nettype wire

FILE: design/stick_dead_zone_direction.sv
// Top level: thumbstick sample to unit direction with a circular dead zone.
// Accepts one (x, y) sample per cycle while req.ready is high and returns
// (dir_x, dir_y) = round(32767*v/|v|): two front stages form |v|^2 and the scaled
// targets, a row of 15 cells decides one result bit each, and one output register
// holds the result. Each stage advances whenever the stage after it is empty or
// moving, so a held result does not block new samples while bubbles remain. The
// dead-zone register takes a write on every csr transaction; write it only while no
// sample is in flight.
`default_nettype none
module stick_dead_zone_direction (
   input  wire logic clock,
   input  wire logic reset,
   sdz_req_if.sink   req,
   sdz_rsp_if.source rsp,
   sdz_csr_if.sink   csr
);
   import sdz_pkg::*;

   localparam int NumCells = QuotWidth;

   logic [14:0] dead_zone_ff;
   logic        chain_vld [0:NumCells];
   logic        chain_rdy [0:NumCells];
   item_type    chain_item [0:NumCells];
   logic [15:0] dir_x, dir_y;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RESET;
      end else if (csr.valid) begin
         dead_zone_ff <= csr.dead_zone;
      end
   end

   sdz_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .stick_x   (req.stick_x),
      .stick_y   (req.stick_y),
      .dead_zone (dead_zone_ff),
      .out_valid (chain_vld[0]),
      .out_ready (chain_rdy[0]),
      .out_item  (chain_item[0])
   );

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      sdz_cell #(.BIT_POS(NumCells - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_vld[i]),
         .in_ready  (chain_rdy[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_vld[i+1]),
         .out_ready (chain_rdy[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   sdz_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_vld[NumCells]),
      .in_ready  (chain_rdy[NumCells]),
      .in_item   (chain_item[NumCells]),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .dir_x     (dir_x),
      .dir_y     (dir_y)
   );

   assign rsp.dir_x = dir_x;
   assign rsp.dir_y = dir_y;
endmodule
`default_nettype wire
